>>> design/biquad_cascade_equalizer_core_defines.svh
// Assertion macros shared by the equaliser core modules.
// No dependencies; the check bodies are compiled out when SYNTH is defined.
`ifndef BIQUAD_CASCADE_EQUALIZER_CORE_DEFINES_SVH
`define BIQUAD_CASCADE_EQUALIZER_CORE_DEFINES_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define BQEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define BQEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BQEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BQEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/bqeq_pkg.sv
// Shared types and constants of the biquad cascade equaliser core.
// Has no dependencies; the controller, the datapath and the core import it.
package bqeq_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 32;
  localparam int COEF_FRAC    = COEF_BITS - 4;
  localparam int NCOEF        = 5;
  localparam int DEF_STAGES   = 7;
  localparam int DEF_CHANNELS = 2;

  localparam logic ACTION_FILTER = 1'b0;
  localparam logic ACTION_COEF   = 1'b1;

  // Coefficient order within one section, also the order of the products.
  typedef enum logic [2:0] {
    TAP_B0,
    TAP_B1,
    TAP_B2,
    TAP_A1,
    TAP_A2
  } coef_tap_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH,
    ST_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic                          action;
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [2:0]                    stage_select;
    logic [2:0]                    coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
  } bqeq_in_t;

  typedef struct packed {
    logic                          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
  } bqeq_out_t;

  typedef struct packed {
    logic      accept;
    logic      issue;
    coef_tap_e tap;
    logic      finish;
    logic      push;
  } bqeq_cmd_t;

  typedef struct packed {
    logic out_free;
  } bqeq_status_t;

endpackage

>>> design/bqeq_ctrl.sv
// Sequencer of the equaliser: walks the sections and the five products of each.
// Depends on bqeq_pkg and the assertion macros header.
`include "biquad_cascade_equalizer_core_defines.svh"

module bqeq_ctrl #(
  parameter int STAGES = bqeq_pkg::DEF_STAGES,
  parameter int STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    action_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_data_i,
  input  bqeq_pkg::bqeq_status_t  status_i,
  output bqeq_pkg::bqeq_cmd_t     cmd_o,
  output logic [STG_W-1:0]        stage_o
);
  import bqeq_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [STG_W-1:0] stage_q, stage_d;
  coef_tap_e        tap_q, tap_d;
  logic             bypass_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign stage_o     = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      stage_q  <= '0;
      tap_q    <= TAP_B0;
      bypass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      tap_q   <= tap_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bypass_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    stage_d      = stage_q;
    tap_d        = tap_q;
    cmd_o        = '0;
    cmd_o.tap    = TAP_B0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (action_i == ACTION_FILTER) begin
            stage_d = '0;
            tap_d   = TAP_B0;
            state_d = bypass_q ? ST_PUSH : ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        cmd_o.tap   = tap_q;
        if (tap_q == TAP_A2) begin
          tap_d   = TAP_B0;
          state_d = ST_DRAIN;
        end else begin
          tap_d = coef_tap_e'(tap_q + 3'd1);
        end
      end
      ST_DRAIN: begin
        // The drain states let the last product pass the multiplier and the adder.
        if (tap_q == TAP_B1) begin
          tap_d   = TAP_B0;
          state_d = ST_FINISH;
        end else begin
          tap_d = TAP_B1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (stage_q == STG_W'(STAGES - 1)) begin
          state_d = ST_PUSH;
        end else begin
          stage_d = stage_q + 1'b1;
          state_d = ST_ISSUE;
        end
      end
      ST_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `BQEQ_ASSERT_NEXT(a_last_tap_drains, clk_i, rst_ni, (state_q == ST_ISSUE) && (tap_q == TAP_A2), state_q == ST_DRAIN, "issue did not stop after the last coefficient")
  `BQEQ_ASSERT_NEXT(a_last_stage_pushes, clk_i, rst_ni, cmd_o.finish && (stage_q == STG_W'(STAGES - 1)), state_q == ST_PUSH, "last section did not lead to the result")
  `BQEQ_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, cmd_o.push, status_i.out_free, "result pushed while the output register is held")
  `BQEQ_ASSERT_IMP(a_stage_in_range, clk_i, rst_ni, state_q != ST_IDLE, int'(stage_q) < STAGES, "section counter out of range")

endmodule

>>> design/bqeq_datapath.sv
// Datapath of the equaliser: coefficient and history memories, one shared
// multiplier, accumulator, rounding and saturation, and the output register.
// Depends on bqeq_pkg and the assertion macros header.
`include "biquad_cascade_equalizer_core_defines.svh"

module bqeq_datapath #(
  parameter int STAGES   = bqeq_pkg::DEF_STAGES,
  parameter int CHANNELS = bqeq_pkg::DEF_CHANNELS,
  parameter int STG_W    = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bqeq_pkg::bqeq_in_t     in_data_i,
  input  bqeq_pkg::bqeq_cmd_t    cmd_i,
  input  logic [STG_W-1:0]       stage_i,
  output bqeq_pkg::bqeq_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bqeq_pkg::bqeq_out_t    out_data_o
);
  import bqeq_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int CDEPTH = STAGES * NCOEF;
  localparam int CA_W   = $clog2(CDEPTH);
  localparam int HROWS  = CHANNELS * STAGES;
  localparam int HR_W   = (HROWS > 1) ? $clog2(HROWS) : 1;
  localparam int PROD_W = SB + COEF_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RND_W  = ACC_W - COEF_FRAC;

  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
  localparam logic [ACC_W-1:0]     HALF     = ACC_W'(1) << (COEF_FRAC - 1);

  // Coefficient table; an entry never written reads as its reset value.
  logic [COEF_BITS-1:0]        coef_mem [CDEPTH];
  logic [CDEPTH-1:0]           coef_vld_q;
  logic                        coef_wr;
  logic [CA_W-1:0]             coef_wr_addr, coef_rd_addr;
  logic signed [COEF_BITS-1:0] coef_q;

  // History rows hold {older, newer} per section and channel.
  logic [2*SB-1:0]             xh_mem [HROWS];
  logic [2*SB-1:0]             yh_mem [HROWS];
  logic [HROWS-1:0]            hist_vld_q;
  logic [2*SB-1:0]             xh_q, yh_q;
  logic                        chan_sel;
  logic [HR_W-1:0]             hist_row;

  logic signed [SB-1:0]        x_q;
  logic                        chan_q;
  logic                        clip_q;

  logic                        mul_v_q, add_v_q;
  coef_tap_e                   mtap_q;
  logic                        neg_q;
  logic signed [SB-1:0]        opnd;
  logic signed [PROD_W-1:0]    prod_q;
  logic [ACC_W-1:0]            prod_ext;
  logic [ACC_W-1:0]            acc_q, acc_rnd;
  logic [RND_W-1:0]            rnd;
  logic [RND_W-SB:0]           rnd_hi;
  logic                        ovf;
  logic signed [SB-1:0]        y_sat;

  logic                        out_valid_q;
  bqeq_out_t                   out_q;

  assign coef_wr = cmd_i.accept && (in_data_i.action == ACTION_COEF) &&
                   (int'(in_data_i.stage_select) < STAGES) &&
                   (int'(in_data_i.coef_index) < NCOEF);
  assign coef_wr_addr = CA_W'(int'(in_data_i.stage_select) * NCOEF +
                              int'(in_data_i.coef_index));
  assign coef_rd_addr = CA_W'(int'(stage_i) * NCOEF + int'(cmd_i.tap));

  // A channel beyond the configured count folds back; the field is one bit.
  assign chan_sel = (CHANNELS > 1) ? chan_q : 1'b0;
  assign hist_row = HR_W'(int'(chan_sel) * STAGES + int'(stage_i));

  always_ff @(posedge clk_i) begin
    if (coef_wr) begin
      coef_mem[coef_wr_addr] <= in_data_i.coef_value;
    end
    if (cmd_i.issue) begin
      if (coef_vld_q[coef_rd_addr]) begin
        coef_q <= coef_mem[coef_rd_addr];
      end else begin
        coef_q <= (cmd_i.tap == TAP_B0) ? COEF_ONE : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      hist_vld_q <= '0;
    end else begin
      if (coef_wr) begin
        coef_vld_q[coef_wr_addr] <= 1'b1;
      end
      if (cmd_i.finish) begin
        hist_vld_q[hist_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue && (cmd_i.tap == TAP_B0)) begin
      xh_q <= hist_vld_q[hist_row] ? xh_mem[hist_row] : '0;
      yh_q <= hist_vld_q[hist_row] ? yh_mem[hist_row] : '0;
    end
    if (cmd_i.finish) begin
      xh_mem[hist_row] <= {xh_q[SB-1:0], x_q};
      yh_mem[hist_row] <= {yh_q[SB-1:0], y_sat};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_data_i.action == ACTION_FILTER)) begin
      x_q    <= in_data_i.sample_in;
      chan_q <= in_data_i.channel;
      clip_q <= 1'b0;
    end else if (cmd_i.finish) begin
      x_q    <= y_sat;
      clip_q <= clip_q | ovf;
    end
  end

  always_comb begin
    case (mtap_q)
      TAP_B0:  opnd = x_q;
      TAP_B1:  opnd = xh_q[SB-1:0];
      TAP_B2:  opnd = xh_q[2*SB-1:SB];
      TAP_A1:  opnd = yh_q[SB-1:0];
      TAP_A2:  opnd = yh_q[2*SB-1:SB];
      default: opnd = x_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      add_v_q <= 1'b0;
    end else begin
      mul_v_q <= cmd_i.issue;
      add_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      mtap_q <= cmd_i.tap;
    end
    if (mul_v_q) begin
      prod_q <= coef_q * opnd;
      neg_q  <= (mtap_q == TAP_A1) || (mtap_q == TAP_A2);
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // The feedback products enter with a minus sign.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue && (cmd_i.tap == TAP_B0)) begin
      acc_q <= '0;
    end else if (add_v_q) begin
      acc_q <= neg_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  // Round half up onto the sample grid, then clamp to the sample range.
  assign acc_rnd = acc_q + HALF;
  assign rnd     = acc_rnd[ACC_W-1:COEF_FRAC];
  assign rnd_hi  = rnd[RND_W-1:SB-1];
  assign ovf     = !((&rnd_hi) || !(|rnd_hi));

  always_comb begin
    if (!ovf) begin
      y_sat = rnd[SB-1:0];
    end else if (rnd[RND_W-1]) begin
      y_sat = {1'b1, {(SB - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SB - 1){1'b1}}};
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.channel_out <= chan_q;
      out_q.sample_out  <= x_q;
      out_q.clipped     <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BQEQ_ASSERT_IMP(a_no_clear_in_flight, clk_i, rst_ni, add_v_q, !(cmd_i.issue && (cmd_i.tap == TAP_B0)), "accumulator cleared while a product is still being added")
  `BQEQ_ASSERT_IMP(a_drained_at_finish, clk_i, rst_ni, cmd_i.finish, !mul_v_q && !add_v_q, "section rounded before its products were summed")
  `BQEQ_ASSERT_IMP(a_no_issue_at_finish, clk_i, rst_ni, cmd_i.finish, !cmd_i.issue && !cmd_i.push, "finish overlaps another command")

endmodule

>>> design/biquad_cascade_equalizer_core.sv
// Filtered sample: each section takes five coefficient reads into the shared
// multiplier, the drain states and one round and write-back; the core takes no new
// item until the result is pushed, and the push waits while the output is held.
// Bypassed sample: goes from the idle state to the push state; no new item meanwhile.
// Coefficient write: one item per cycle while the core is idle.
// Reset (asynchronous, active low) clears control and the valid bits, so history
// reads as zero and every section as b0 = 1.0 straight away, with no clearing pass.
module biquad_cascade_equalizer_core #(
  parameter int STAGES   = bqeq_pkg::DEF_STAGES,
  parameter int CHANNELS = bqeq_pkg::DEF_CHANNELS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bqeq_pkg::bqeq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bqeq_pkg::bqeq_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import bqeq_pkg::*;

  localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;

  bqeq_cmd_t        cmd;
  bqeq_status_t     status;
  logic [STG_W-1:0] stage;

  bqeq_ctrl #(
    .STAGES (STAGES),
    .STG_W  (STG_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (in_data_i.action),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .stage_o     (stage)
  );

  bqeq_datapath #(
    .STAGES   (STAGES),
    .CHANNELS (CHANNELS),
    .STG_W    (STG_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stage_i     (stage),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/bqeq_checker.sv
// Checker for the biquad cascade equaliser core: it watches the sample, result and
// bypass-register channels, predicts each filtered sample and compares it field by field.
// Depends on bqeq_pkg for the item types, the tap order and the widths.
module bqeq_checker
  import bqeq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  bqeq_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  bqeq_out_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic      cfg_data_i,
  output int        fails_o,
  output int        pending_o
);

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic signed [SAMPLE_BITS-1:0] x_hist [DEF_CHANNELS][DEF_STAGES][2];
  logic signed [SAMPLE_BITS-1:0] y_hist [DEF_CHANNELS][DEF_STAGES][2];
  logic signed [COEF_BITS-1:0]   coef_table [DEF_STAGES][NCOEF];
  logic                          bypass_on;
  bqeq_out_t                     expected_samples [$];
  bqeq_out_t                     want;

  function automatic void clear_state();
    for (int c = 0; c < DEF_CHANNELS; c++) begin
      for (int s = 0; s < DEF_STAGES; s++) begin
        x_hist[c][s][0] = '0;
        x_hist[c][s][1] = '0;
        y_hist[c][s][0] = '0;
        y_hist[c][s][1] = '0;
      end
    end
    for (int s = 0; s < DEF_STAGES; s++) begin
      for (int t = 0; t < NCOEF; t++) begin
        coef_table[s][t] = '0;
      end
      coef_table[s][TAP_B0] = COEF_BITS'(longint'(1) <<< COEF_FRAC);
    end
    bypass_on = 1'b0;
  endfunction

  // Unless bypass is on, runs one sample through all sections, updating the history of its channel.
  function automatic bqeq_out_t filter_sample(logic ch, logic signed [SAMPLE_BITS-1:0] smp);
    bqeq_out_t                     res;
    longint                        acc;
    logic signed [SAMPLE_BITS-1:0] x;
    int                            c;
    res.channel_out = ch;
    res.sample_out  = smp;
    res.clipped     = 1'b0;
    if (bypass_on) begin
      return res;
    end
    c = int'(ch) % DEF_CHANNELS;
    x = smp;
    for (int s = 0; s < DEF_STAGES; s++) begin
      acc = longint'(coef_table[s][TAP_B0]) * longint'(x)
          + longint'(coef_table[s][TAP_B1]) * longint'(x_hist[c][s][0])
          + longint'(coef_table[s][TAP_B2]) * longint'(x_hist[c][s][1])
          - longint'(coef_table[s][TAP_A1]) * longint'(y_hist[c][s][0])
          - longint'(coef_table[s][TAP_A2]) * longint'(y_hist[c][s][1]);
      // Round half up onto the sample grid, then saturate.
      acc = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (acc > SAT_HI) begin
        acc = SAT_HI;
        res.clipped = 1'b1;
      end
      if (acc < SAT_LO) begin
        acc = SAT_LO;
        res.clipped = 1'b1;
      end
      x_hist[c][s][1] = x_hist[c][s][0];
      x_hist[c][s][0] = x;
      y_hist[c][s][1] = y_hist[c][s][0];
      y_hist[c][s][0] = acc[SAMPLE_BITS-1:0];
      x = acc[SAMPLE_BITS-1:0];
    end
    res.sample_out = x;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_samples.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        bypass_on = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result item: channel_out %0d sample_out %0d clipped %0d",
                 out_data_i.channel_out, $signed(out_data_i.sample_out), out_data_i.clipped);
          fails_o++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data_i.channel_out !== want.channel_out) begin
            $error("channel_out: expected %0d, got %0d",
                   want.channel_out, out_data_i.channel_out);
            fails_o++;
          end
          if (out_data_i.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample_out), $signed(out_data_i.sample_out));
            fails_o++;
          end
          if (out_data_i.clipped !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, out_data_i.clipped);
            fails_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.action == ACTION_COEF) begin
          // Writes to a section or tap that does not exist are dropped.
          if (in_data_i.stage_select < DEF_STAGES && in_data_i.coef_index < NCOEF) begin
            coef_table[in_data_i.stage_select][in_data_i.coef_index] = in_data_i.coef_value;
          end
        end else begin
          expected_samples.push_back(filter_sample(in_data_i.channel, in_data_i.sample_in));
        end
      end
      pending_o = expected_samples.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the equaliser testbench: clock, reset, sample and coefficient stimulus,
// bypass register writes and the verdict. Depends on bqeq_pkg, the core and bqeq_checker.
module tb_top;
  import bqeq_pkg::*;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [COEF_BITS-1:0]   C_MAX = {1'b0, {(COEF_BITS - 1){1'b1}}};
  localparam logic [COEF_BITS-1:0]   C_MIN = {1'b1, {(COEF_BITS - 1){1'b0}}};
  localparam logic [COEF_BITS-1:0]   C_ONE = COEF_BITS'(longint'(1) <<< COEF_FRAC);

  localparam int SEGMENT_ITEMS = 130;
  localparam int CFG_PAUSE     = 8;
  localparam int DRAIN_CYCLES  = 64;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  bqeq_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  bqeq_out_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;

  int tx_idle_pct;
  int rx_idle_pct;
  int fails;
  int pending;

  biquad_cascade_equalizer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  bqeq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
    end
    if (pick == 1) begin
      return SAMPLE_BITS'(int'($urandom_range(0, 4096)) - 2048);
    end
    return SAMPLE_BITS'($urandom());
  endfunction

  // Mostly moderate values so that the cascade does not sit on the rails all the time.
  function automatic logic [COEF_BITS-1:0] rand_coef(logic [2:0] tap);
    int pick;
    int span;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      return COEF_BITS'($urandom());
    end
    if (pick < 6) begin
      span = 1 << 20;
    end else if (tap == TAP_A1) begin
      span = 1 << COEF_FRAC;
    end else begin
      span = 1 << (COEF_FRAC - 1);
    end
    return COEF_BITS'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic bqeq_in_t sample_item(logic ch, logic [SAMPLE_BITS-1:0] smp);
    bqeq_in_t it;
    it.action       = ACTION_FILTER;
    it.channel      = ch;
    it.sample_in    = smp;
    it.stage_select = 3'($urandom());
    it.coef_index   = 3'($urandom());
    it.coef_value   = COEF_BITS'($urandom());
    return it;
  endfunction

  function automatic bqeq_in_t coef_item(logic [2:0] stage, logic [2:0] tap,
                                         logic [COEF_BITS-1:0] value);
    bqeq_in_t it;
    it.action       = ACTION_COEF;
    it.channel      = 1'($urandom());
    it.sample_in    = SAMPLE_BITS'($urandom());
    it.stage_select = stage;
    it.coef_index   = tap;
    it.coef_value   = value;
    return it;
  endfunction

  // Entered and left at a falling edge; valid stays high between back-to-back items.
  task automatic send_item(input bqeq_in_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain(input int extra_cycles);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (extra_cycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic value);
    drain(CFG_PAUSE);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_coefficient_set();
    for (int s = 0; s < DEF_STAGES; s++) begin
      for (int t = 0; t < NCOEF; t++) begin
        send_item(coef_item(3'(s), 3'(t), rand_coef(3'(t))));
      end
    end
  endtask

  initial begin : stimulus
    logic [2:0] stage;
    logic [2:0] tap;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_ni      = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset coefficients pass every sample straight through.
    send_item(sample_item(CH_LEFT, S_MAX));
    send_item(sample_item(CH_RIGHT, S_MIN));
    send_item(sample_item(CH_LEFT, '0));
    // Largest gain in the first section drives both rails.
    send_item(coef_item(3'(0), TAP_B0, C_MAX));
    send_item(sample_item(CH_LEFT, S_MAX));
    send_item(sample_item(CH_RIGHT, S_MIN));
    send_item(coef_item(3'(1), TAP_B1, C_ONE));
    send_item(coef_item(3'(2), TAP_B2, -C_ONE));
    send_item(coef_item(3'(3), TAP_A1, C_ONE >> 1));
    send_item(coef_item(3'(DEF_STAGES - 1), TAP_A2, C_MIN));
    // Writes outside the table must leave it alone.
    send_item(coef_item(3'(DEF_STAGES), TAP_B0, C_MIN));
    send_item(coef_item(3'(4), 3'(NCOEF), C_MAX));
    send_item(coef_item(3'(5), 3'(NCOEF + 2), C_MIN));
    send_item(sample_item(CH_LEFT, 24'h123456));
    send_item(sample_item(CH_RIGHT, 24'hEDCBA9));
    send_item(sample_item(CH_LEFT, 24'h000001));
    send_item(sample_item(CH_RIGHT, S_MAX));
    cfg_write(1'b1);
    send_item(sample_item(CH_LEFT, S_MAX));
    send_item(sample_item(CH_RIGHT, S_MIN));
    send_item(sample_item(CH_LEFT, 24'h5A5A5A));
    cfg_write(1'b0);
    send_item(sample_item(CH_RIGHT, 24'h654321));

    for (int phase = 0; phase < 3; phase++) begin
      drain(0);
      case (phase)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        cfg_write($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) != 0) begin
          load_coefficient_set();
        end
        for (int n = 0; n < SEGMENT_ITEMS; n++) begin
          if ($urandom_range(0, 4) != 0) begin
            send_item(sample_item(1'($urandom()), rand_sample()));
          end else begin
            stage = ($urandom_range(0, 9) == 0) ? 3'($urandom())
                                                : 3'($urandom_range(0, DEF_STAGES - 1));
            tap   = ($urandom_range(0, 9) == 0) ? 3'($urandom())
                                                : 3'($urandom_range(0, NCOEF - 1));
            send_item(coef_item(stage, tap, rand_coef(tap)));
          end
        end
      end
    end

    drain(DRAIN_CYCLES);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
